### hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants for the standardized linear projection core.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int NUM_STATS_DEF = 64;
    localparam int NUM_COMB_DEF  = 8;
    localparam int MAX_OUT       = 8;

    // request codes on the input beat
    localparam logic [1:0] REQ_PARAM  = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // divider: |(x - mean) * 2^16| needs 49 bits
    localparam int DIV_BITS = 49;

    localparam logic [3:0] NUM_COMB_RST = 4'd8;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         stat_index;
        logic [2:0]         comb_index;
        logic               stat_used;
        logic signed [31:0] mean_value;
        logic signed [31:0] sd_value;
        logic signed [31:0] weight_value;
        logic signed [31:0] sample_value;
        logic               last_stat;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_comb_index;
        logic signed [47:0] comb_value;
        logic               last_comb;
        logic               sd_zero_error;
    } out_item_t;

    // command handed from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         stat_index;
        logic [2:0]         comb_index;
        logic               stat_used;
        logic               in_range;
        logic               last_stat;
        logic signed [31:0] data;
        logic signed [31:0] sd;
    } cmd_t;

endpackage

### hw/rtl/standardized_linear_projection_core.sv
// ----------------------------------------------------------------------------
// standardized_linear_projection_core
// Loads mean/sd/weight tables, then projects standardized samples onto up to
// eight weight vectors and emits the saturated combination sums.
// ----------------------------------------------------------------------------
// Loads and unused samples retire in the idle back end. A used sample passes
// lookup, the serial divider (one quotient bit a cycle), saturation, then a
// weight read, multiply and accumulate for each of n active combinations.
// On the last sample, n result beats follow, one per cycle when not stalled.
// Reset: async active low; clears used flags, sums, error flag, queues, and
// sets num_combinations to 8. Mean, sd and weight tables are not cleared.
module standardized_linear_projection_core
    import slp_pkg::*;
#(
    parameter int NUM_STATS = NUM_STATS_DEF,
    parameter int NUM_COMB  = NUM_COMB_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // input queue side
    input  logic       push,
    output logic       full,
    input  in_item_t   req,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output out_item_t  rsp,
    // num_combinations register
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    localparam int LIM = (NUM_COMB < MAX_OUT) ? NUM_COMB : MAX_OUT;
    localparam int CMD_W = $bits(cmd_t);
    localparam int OUT_W = $bits(out_item_t);

    logic [3:0] num_comb_reg;
    logic [3:0] n_active;

    logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t       cmd_in, cmd_out;
    logic       out_push, out_full;
    out_item_t  out_data;

    // the user must set the count only while the core is idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_comb_reg <= NUM_COMB_RST;
        end
        else if (cfg_we)
        begin
            num_comb_reg <= cfg_data;
        end
    end

    // clamp the active count to 1 .. LIM
    always_comb
    begin
        if (num_comb_reg == '0)
            n_active = 4'd1;
        else if (num_comb_reg > 4'(LIM))
            n_active = 4'(LIM);
        else
            n_active = num_comb_reg;
    end

    // front: accept beats and classify them into commands
    slp_front #(.NUM_STATS(NUM_STATS), .NUM_COMB(NUM_COMB)) u_front (
        .item     (req),
        .push     (push),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    assign full = cmd_full;

    // decouple front and back so each stalls on its own
    slp_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    // back: table writes, divide, multiply-accumulate, emit
    slp_back #(.NUM_STATS(NUM_STATS), .NUM_COMB(NUM_COMB)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .n_active  (n_active),
        .out_push  (out_push),
        .out_data  (out_data),
        .out_full  (out_full)
    );

    // result queue: one full run of beats fits
    slp_fifo #(.WIDTH(OUT_W), .DEPTH(MAX_OUT)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty)
    );

endmodule

### hw/rtl/slp_ram.sv
// ----------------------------------------------------------------------------
// slp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/slp_fifo.sv
// ----------------------------------------------------------------------------
// slp_fifo
// Small register FIFO with full/empty flags.
// ----------------------------------------------------------------------------
module slp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/slp_front.sv
// ----------------------------------------------------------------------------
// slp_front
// Classify input beats: range-check, drop no-op requests, build commands.
// ----------------------------------------------------------------------------
module slp_front
    import slp_pkg::*;
#(
    parameter int NUM_STATS = NUM_STATS_DEF,
    parameter int NUM_COMB  = NUM_COMB_DEF
) (
    input  in_item_t item,
    input  logic     push,
    input  logic     cmd_full,
    output logic     cmd_push,
    output cmd_t     cmd
);

    logic stat_ok, comb_ok, keep;

    assign stat_ok = (32'(item.stat_index) < 32'(NUM_STATS));
    assign comb_ok = (32'(item.comb_index) < 32'(NUM_COMB));

    always_comb
    begin
        unique case (item.req_type)
            REQ_PARAM:  keep = stat_ok;
            REQ_WEIGHT: keep = stat_ok && comb_ok;
            REQ_SAMPLE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.op         = item.req_type;
        cmd.stat_index = item.stat_index;
        cmd.comb_index = item.comb_index;
        cmd.stat_used  = item.stat_used;
        cmd.in_range   = stat_ok;
        cmd.last_stat  = item.last_stat;
        cmd.sd         = item.sd_value;
        unique case (item.req_type)
            REQ_PARAM:  cmd.data = item.mean_value;
            REQ_WEIGHT: cmd.data = item.weight_value;
            default:    cmd.data = item.sample_value;
        endcase
    end

    // drop loads that fall outside the tables and unknown requests
    assign cmd_push = push && !cmd_full && keep;

endmodule

### hw/rtl/slp_back.sv
// ----------------------------------------------------------------------------
// slp_back
// Execute commands: table writes, standardize by serial divide, MAC, emit.
// ----------------------------------------------------------------------------
module slp_back
    import slp_pkg::*;
#(
    parameter int NUM_STATS = NUM_STATS_DEF,
    parameter int NUM_COMB  = NUM_COMB_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_empty,
    output logic       cmd_pop,
    input  logic [3:0] n_active,
    output logic       out_push,
    output out_item_t  out_data,
    input  logic       out_full
);

    localparam int SAW = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
    localparam int CAW = (NUM_COMB > 1) ? $clog2(NUM_COMB) : 1;
    localparam int LIM = (NUM_COMB < MAX_OUT) ? NUM_COMB : MAX_OUT;
    localparam int KW  = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int WDEPTH = NUM_STATS * (2 ** CAW);
    localparam int CNTW = $clog2(DIV_BITS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SAT    = 3'd3;
    localparam logic [2:0] ST_WRD    = 3'd4;
    localparam logic [2:0] ST_WMUL   = 3'd5;
    localparam logic [2:0] ST_WACC   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [NUM_STATS-1:0]  used_reg;
    logic [SAW-1:0]        sa_reg;
    logic signed [31:0]    x_reg;
    logic                  last_reg;
    logic                  err_reg;
    logic [3:0]            k_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  neg_reg;
    logic [DIV_BITS-1:0]   quo_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           dvs_reg;
    logic signed [31:0]    z_reg;
    logic signed [63:0]    prod_reg;
    logic signed [47:0]    acc_reg [LIM];

    logic [SAW-1:0]        cmd_sa;
    logic [63:0]           ms_rdata;
    logic [31:0]           w_rdata;
    logic                  ms_we, w_we;
    logic [SAW+CAW-1:0]    w_waddr, w_raddr;
    logic signed [31:0]    mean_rd, sd_rd;
    logic signed [32:0]    diff;
    logic signed [48:0]    num;
    logic [DIV_BITS-1:0]   num_mag;
    logic [32:0]           rem_sh;
    logic                  q_bit;
    logic [DIV_BITS-1:0]   neg_mag;
    logic signed [47:0]    term;
    logic signed [48:0]    sum;
    logic signed [47:0]    sum_sat;
    logic                  k_last;

    assign cmd_sa  = SAW'(cmd.stat_index);
    assign mean_rd = ms_rdata[63:32];
    assign sd_rd   = ms_rdata[31:0];
    assign k_last  = (k_reg + 4'd1 == n_active);

    assign ms_we   = (state_reg == ST_IDLE) && !cmd_empty && (cmd.op == REQ_PARAM);
    assign w_we    = (state_reg == ST_IDLE) && !cmd_empty && (cmd.op == REQ_WEIGHT);
    assign w_waddr = {cmd_sa, CAW'(cmd.comb_index)};
    assign w_raddr = {sa_reg, CAW'(k_reg)};
    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;

    slp_ram #(.WIDTH(64), .DEPTH(NUM_STATS)) u_ms_ram (
        .clk   (clk),
        .we    (ms_we),
        .waddr (cmd_sa),
        .wdata ({cmd.data, cmd.sd}),
        .raddr (cmd_sa),
        .rdata (ms_rdata)
    );

    slp_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_w_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (cmd.data),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // standardize front end
    assign diff    = 33'(x_reg) - 33'(mean_rd);
    assign num     = {diff, 16'd0};
    assign num_mag = num[48] ? DIV_BITS'(-num) : DIV_BITS'(num);

    // one restoring-divide step
    assign rem_sh = {rem_reg, quo_reg[DIV_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});
    assign neg_mag = '0 - quo_reg;

    // accumulate with floor shift and 48-bit saturation
    assign term = prod_reg[63:16];
    assign sum  = 49'(acc_reg[k_reg[KW-1:0]]) + 49'(term);
    assign sum_sat = (sum[48] != sum[47]) ? (sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                                          : sum[47:0];

    assign out_push = (state_reg == ST_EMIT) && !out_full;
    always_comb
    begin
        out_data.out_comb_index = 3'(k_reg);
        out_data.comb_value     = acc_reg[k_reg[KW-1:0]];
        out_data.last_comb      = k_last;
        out_data.sd_zero_error  = err_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && cmd.op == REQ_SAMPLE)
                begin
                    if (cmd.in_range && used_reg[cmd_sa])
                        state_next = ST_LOOKUP;
                    else if (cmd.last_stat)
                        state_next = ST_EMIT;
                end
            end
            ST_LOOKUP: state_next = (sd_rd == '0) ? (last_reg ? ST_EMIT : ST_IDLE) : ST_DIV;
            ST_DIV:    state_next = (cnt_reg == CNTW'(1)) ? ST_SAT : ST_DIV;
            ST_SAT:    state_next = ST_WRD;
            ST_WRD:    state_next = ST_WMUL;
            ST_WMUL:   state_next = ST_WACC;
            ST_WACC:   state_next = k_last ? (last_reg ? ST_EMIT : ST_IDLE) : ST_WRD;
            ST_EMIT:   state_next = (out_push && k_last) ? ST_IDLE : ST_EMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            err_reg   <= 1'b0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
            for (int i = 0; i < LIM; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    k_reg <= '0;
                    if (!cmd_empty)
                    begin
                        if (cmd.op == REQ_PARAM)
                            used_reg[cmd_sa] <= cmd.stat_used;
                        last_reg <= cmd.last_stat;
                    end
                end
                ST_LOOKUP:
                begin
                    if (sd_rd == '0)
                        err_reg <= 1'b1;
                end
                ST_WACC:
                begin
                    acc_reg[k_reg[KW-1:0]] <= sum_sat;
                    k_reg <= k_last ? '0 : k_reg + 4'd1;
                end
                ST_EMIT:
                begin
                    if (out_push)
                    begin
                        if (k_last)
                        begin
                            // clear for the next sample vector
                            err_reg <= 1'b0;
                            k_reg   <= '0;
                            for (int i = 0; i < LIM; i++)
                            begin
                                acc_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            sa_reg <= cmd_sa;
            x_reg  <= cmd.data;
        end
        if (state_reg == ST_LOOKUP)
        begin
            neg_reg <= num[48] ^ sd_rd[31];
            quo_reg <= num_mag;
            rem_reg <= '0;
            dvs_reg <= sd_rd[31] ? 32'(-sd_rd) : 32'(sd_rd);
            cnt_reg <= CNTW'(DIV_BITS);
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= q_bit ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], q_bit};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == ST_SAT)
        begin
            if (neg_reg)
                z_reg <= (quo_reg > DIV_BITS'(33'h80000000)) ? 32'sh80000000
                                                             : neg_mag[31:0];
            else
                z_reg <= (quo_reg > DIV_BITS'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                             : quo_reg[31:0];
        end
        if (state_reg == ST_WMUL)
        begin
            prod_reg <= $signed(w_rdata) * z_reg;
        end
    end

endmodule

### tb/slp_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slp_scoreboard
// Watches the request, result and register ports of the projection core,
// keeps its own copy of the tables and sums, predicts the result beats of
// every accepted sample and compares each popped beat with the oldest one.
// ----------------------------------------------------------------------------
module slp_scoreboard
    import slp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  in_item_t   req,
    input  logic       empty,
    input  logic       pop,
    input  out_item_t  rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data,
    output int         errors,
    output int         pending
);

    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -64'sd140737488355328;

    logic               used_tab [NUM_STATS_DEF];
    logic signed [31:0] mean_tab [NUM_STATS_DEF];
    logic signed [31:0] sd_tab   [NUM_STATS_DEF];
    logic signed [31:0] wt_tab   [NUM_STATS_DEF*NUM_COMB_DEF];
    longint             sums     [NUM_COMB_DEF];
    logic               zero_sd_seen;
    logic [3:0]         comb_cnt;
    out_item_t          beats_due[$];
    int                 mismatches;

    assign errors = mismatches;

    function automatic int active_combs(logic [3:0] v);
        if (v < 1) return 1;
        if (v > NUM_COMB_DEF) return NUM_COMB_DEF;
        return int'(v);
    endfunction

    // Update the tables or the sums for one request beat; queue result beats.
    task automatic project(in_item_t it);
        int     n;
        longint z;
        longint term;
        longint s;
        out_item_t o;
        n = active_combs(comb_cnt);
        case (it.req_type)
            REQ_PARAM:
            begin
                used_tab[it.stat_index] = it.stat_used;
                mean_tab[it.stat_index] = it.mean_value;
                sd_tab[it.stat_index]   = it.sd_value;
            end
            REQ_WEIGHT:
                wt_tab[{it.stat_index, it.comb_index}] = it.weight_value;
            REQ_SAMPLE:
            begin
                if (used_tab[it.stat_index])
                begin
                    if (sd_tab[it.stat_index] == 0)
                    begin
                        zero_sd_seen = 1'b1;
                    end
                    else
                    begin
                        z = ((longint'(it.sample_value) - longint'(mean_tab[it.stat_index]))
                             * 65536) / longint'(sd_tab[it.stat_index]);
                        if (z > 64'sd2147483647) z = 64'sd2147483647;
                        if (z < -64'sd2147483648) z = -64'sd2147483648;
                        for (int k = 0; k < n; k++)
                        begin
                            term = (longint'(wt_tab[{it.stat_index, 3'(k)}]) * z) >>> 16;
                            s = sums[k] + term;
                            if (s > SUM_MAX) s = SUM_MAX;
                            if (s < SUM_MIN) s = SUM_MIN;
                            sums[k] = s;
                        end
                    end
                end
                if (it.last_stat)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        o.out_comb_index = 3'(k);
                        o.comb_value     = sums[k][47:0];
                        o.last_comb      = (k + 1 == n);
                        o.sd_zero_error  = zero_sd_seen;
                        beats_due = {beats_due, o};
                        sums[k] = 0;
                    end
                    zero_sd_seen = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATS_DEF; i++) used_tab[i] = 1'b0;
            for (int k = 0; k < NUM_COMB_DEF; k++) sums[k] = 0;
            zero_sd_seen = 1'b0;
            comb_cnt     = NUM_COMB_RST;
            beats_due.delete();
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (beats_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result beat %p", $realtime, rsp);
                end
                else
                begin
                    e = beats_due.pop_front();
                    if (rsp.out_comb_index !== e.out_comb_index ||
                        rsp.comb_value !== e.comb_value ||
                        rsp.last_comb !== e.last_comb ||
                        rsp.sd_zero_error !== e.sd_zero_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t result mismatch: expected %p, got %p",
                                     $realtime, e, rsp);
                    end
                end
            end
            if (push && !full) project(req);
            if (cfg_we) comb_cnt = cfg_data;
            pending = beats_due.size();
        end
    end

endmodule

### tb/standardized_linear_projection_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// standardized_linear_projection_core_tb
// Drives table loads and sample vectors into the projection core through
// several settings of the combination count, with bursty input and a
// stalling result side; the scoreboard predicts and checks every beat.
// ----------------------------------------------------------------------------
module standardized_linear_projection_core_tb;
    import slp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // longer than two queued commands plus one in the back end take to retire
    localparam int DRAIN_WAIT  = 400;
    localparam int IN_W        = $bits(in_item_t);
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   req;
    logic       empty;
    logic       pop;
    out_item_t  rsp;
    logic       cfg_we;
    logic [3:0] cfg_data;
    int         errors;
    int         pending;

    int  cycles;
    bit  hold_request;
    int  burst_left;
    int  beats_sent;
    int  vectors_done;

    // Legality shadow: a used stat with nonzero sd needs all its weights.
    bit       used_sh [NUM_STATS_DEF];
    bit       sdz_sh  [NUM_STATS_DEF];
    bit [7:0] wmask   [NUM_STATS_DEF];
    int       ready_stats[$];

    standardized_linear_projection_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req      (req),
        .empty    (empty),
        .pop      (pop),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    slp_scoreboard checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req      (req),
        .empty    (empty),
        .pop      (pop),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: abort a hung run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("standardized_linear_projection_core_tb: errors");
                $finish;
            end
        end
    end

    // Result side: switch among random stall patterns; once, hold off long
    // enough that the core backs up and raises full.
    initial
    begin
        int mode;
        int span;
        pop  = 1'b0;
        mode = 0;
        span = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (3000) @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = 64;
                end
                span--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= $urandom_range(0, 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            3: return 32'sh00010000;
            default: return $urandom();
        endcase
    endfunction

    // Random filler for the fields a request does not use.
    function automatic in_item_t rand_fill();
        logic [159:0] noise_bits;
        noise_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return in_item_t'(noise_bits[IN_W-1:0]);
    endfunction

    function automatic bit sample_ok(int si);
        return !used_sh[si] || sdz_sh[si] || wmask[si] == 8'hFF;
    endfunction

    // Offer one beat; hold it until accepted. Gaps fall between bursts.
    task automatic send(in_item_t it);
        if (burst_left == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        push <= 1'b1;
        req  <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        burst_left--;
        beats_sent++;
        case (it.req_type)
            REQ_PARAM:
            begin
                used_sh[it.stat_index] = it.stat_used;
                sdz_sh[it.stat_index]  = (it.sd_value == 0);
                wmask[it.stat_index]   = 8'h00;
            end
            REQ_WEIGHT: wmask[it.stat_index][it.comb_index] = 1'b1;
            REQ_SAMPLE: if (it.last_stat) vectors_done++;
            default: ;
        endcase
    endtask

    task automatic load_param(int si, bit used, logic signed [31:0] mean,
                              logic signed [31:0] sd);
        in_item_t it;
        it = rand_fill();
        it.req_type   = REQ_PARAM;
        it.stat_index = 6'(si);
        it.stat_used  = used;
        it.mean_value = mean;
        it.sd_value   = sd;
        send(it);
    endtask

    task automatic load_weight(int si, int ci, logic signed [31:0] w);
        in_item_t it;
        it = rand_fill();
        it.req_type     = REQ_WEIGHT;
        it.stat_index   = 6'(si);
        it.comb_index   = 3'(ci);
        it.weight_value = w;
        send(it);
    endtask

    task automatic sample(int si, logic signed [31:0] x, bit last);
        in_item_t it;
        it = rand_fill();
        it.req_type     = REQ_SAMPLE;
        it.stat_index   = 6'(si);
        it.sample_value = x;
        it.last_stat    = last;
        send(it);
    endtask

    // Load one stat fully: parameters then all eight weights.
    task automatic prepare_stat(int si);
        bit used;
        logic signed [31:0] sd;
        used = ($urandom_range(0, 5) != 0);
        sd   = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_word();
        if (sd == 0 && $urandom_range(0, 1)) sd = 32'sh00010000;
        load_param(si, used, rand_word(), sd);
        for (int k = 0; k < NUM_COMB_DEF; k++) load_weight(si, k, rand_word());
        ready_stats = {ready_stats, si};
    endtask

    // Drop any beat: wait for outstanding results, let loads retire, set count.
    task automatic settle_and_config(logic [3:0] v);
        @(negedge clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_traffic(int beat_goal, int vector_goal);
        int si;
        int len;
        int start_beats;
        int start_vec;
        in_item_t it;
        start_beats = beats_sent;
        start_vec   = vectors_done;
        while (beats_sent - start_beats < beat_goal || vectors_done - start_vec < vector_goal)
        begin
            case ($urandom_range(0, 9))
                0, 1: prepare_stat($urandom_range(0, 63));
                2:
                begin
                    // noise: stray loads and ignored request code
                    it = rand_fill();
                    if ($urandom_range(0, 1))
                    begin
                        it.req_type = REQ_UNUSED;
                        send(it);
                    end
                    else
                    begin
                        load_weight($urandom_range(0, 63), $urandom_range(0, 7), rand_word());
                    end
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    for (int j = 0; j < len; j++)
                    begin
                        si = $urandom_range(0, 63);
                        if (ready_stats.size() > 0 && $urandom_range(0, 3) != 0)
                            si = ready_stats[$urandom_range(0, ready_stats.size() - 1)];
                        if (!sample_ok(si)) si = ready_stats.size() > 0 ? ready_stats[0] : si;
                        if (sample_ok(si)) sample(si, rand_word(), j == len - 1);
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        logic [3:0] phase_cfg [5];
        phase_cfg    = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd5};
        rst_n        = 1'b0;
        push         = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_data     = 4'd0;
        hold_request = 1'b0;
        burst_left   = 0;
        beats_sent   = 0;
        vectors_done = 0;
        for (int i = 0; i < NUM_STATS_DEF; i++)
        begin
            used_sh[i] = 0;
            sdz_sh[i]  = 0;
            wmask[i]   = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: full-scale weights on stat 63, unit scale on stat 0,
        // a zero-sd stat, an unused stat with the last flag, code 3 all ones.
        settle_and_config(4'd8);
        load_param(63, 1'b1, 32'sh80000000, 32'sh00010000);
        load_param(0, 1'b1, 32'sh00000000, 32'sh00010000);
        load_param(5, 1'b1, 32'sh00001234, 32'sd0);
        load_param(9, 1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        for (int k = 0; k < NUM_COMB_DEF; k++)
            load_weight(63, k, (k % 2) ? 32'sh80000000 : 32'sh7FFFFFFF);
        ready_stats = {ready_stats, 63};
        sample(63, 32'sh7FFFFFFF, 1'b0);
        sample(63, 32'sh7FFFFFFF, 1'b0);
        sample(63, 32'sh7FFFFFFF, 1'b0);
        sample(5, 32'sh00050000, 1'b0);
        sample(9, 32'sh80000000, 1'b1);
        begin
            in_item_t it;
            it = '1;
            it.req_type = REQ_UNUSED;
            send(it);
        end
        sample(63, 32'sh80000000, 1'b1);

        // Random phases, one combination count each; the all-eight phase
        // holds the result side off while input keeps coming, so it backs up.
        foreach (phase_cfg[p])
        begin
            settle_and_config(phase_cfg[p]);
            if (p == 1)
                hold_request = 1'b1;
            random_traffic(17, 3);
        end

        @(negedge clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("standardized_linear_projection_core_tb: clean");
        else
            $display("standardized_linear_projection_core_tb: errors");
        $finish;
    end

endmodule
